// ===== rtl/core/utf8d_pkg.sv =====
// Package: shared types and constants for the UTF-8 stream decoder.
package utf8d_pkg;

    localparam int unsigned CP_W   = 21;
    localparam int unsigned LINE_W = 24;
    localparam int unsigned REM_W  = 2;

    localparam logic [7:0]        NEWLINE  = 8'h0A;
    localparam logic [LINE_W-1:0] LINE_MAX = {LINE_W{1'b1}};

    // Count of continuation bytes still expected.
    localparam logic [REM_W-1:0] REM_NONE  = 2'd0;
    localparam logic [REM_W-1:0] REM_ONE   = 2'd1;
    localparam logic [REM_W-1:0] REM_TWO   = 2'd2;
    localparam logic [REM_W-1:0] REM_THREE = 2'd3;

    typedef struct packed {
        logic [CP_W-1:0]   partial;
        logic [REM_W-1:0]  remaining;
        logic [LINE_W-1:0] line;
    } t_dec_state;

    typedef struct packed {
        logic              emit;
        logic [CP_W-1:0]   code_point;
        logic              end_seen;
        logic [LINE_W-1:0] line_number;
    } t_dec_result;

endpackage

// ===== rtl/core/utf8_stream_decoder.sv =====
// Top level: UTF-8 byte stream decoder with saturating line counter.
//
// One byte (or an end-of-stream marker) enters per accepted item. Items
// pass through an input register, one level of decode logic and a result
// register, so the block sustains one byte per cycle while the output is not stalled; the only feedback is
// the small decode state (partial code point, continuation count, line
// count), updated in the same cycle an item leaves the input register.
// A result is written to the result register as its item leaves the
// input register. A byte in the middle of a multi-byte sequence yields
// no result. An end marker yields a result with code_point zero,
// o_end_seen high and the current line number, and drops any partial
// sequence. Continuation bytes are not checked, and stray or invalid
// lead bytes pass through as their own code point. The input stall
// rises only when the input register holds an item that has a result to
// deliver while the result register is full and stalled.
module utf8_stream_decoder
    import utf8d_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [7:0]        i_data_byte,
    input  logic              i_stream_end,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [CP_W-1:0]   o_code_point,
    output logic              o_end_seen,
    output logic [LINE_W-1:0] o_line_number
);

    // Input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_end;

    // Decode state
    t_dec_state  r_state;
    t_dec_state  n_state;
    t_dec_result step_res;

    // Result register
    logic              r_out_valid;
    logic [CP_W-1:0]   r_code_point;
    logic              r_end_seen;
    logic [LINE_W-1:0] r_line_number;

    logic advance;

    utf8d_step u_step (
        .i_state      (r_state),
        .i_data_byte  (r_in_byte),
        .i_stream_end (r_in_end),
        .o_state      (n_state),
        .o_result     (step_res)
    );

    // Advance the held item unless its result would land on a stalled full slot.
    assign advance    = r_in_valid && (!step_res.emit || !r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_byte <= i_data_byte;
            r_in_end  <= i_stream_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.partial   <= '0;
            r_state.remaining <= REM_NONE;
            r_state.line      <= LINE_W'(1);
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // Hold the result while stalled; drop it once taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && step_res.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && step_res.emit) begin
            r_code_point  <= step_res.code_point;
            r_end_seen    <= step_res.end_seen;
            r_line_number <= step_res.line_number;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_code_point  = r_code_point;
    assign o_end_seen    = r_end_seen;
    assign o_line_number = r_line_number;

endmodule

// ===== rtl/core/utf8d_step.sv =====
// Decode step: next decoder state and optional result for one byte or end marker.
module utf8d_step
    import utf8d_pkg::*;
(
    input  t_dec_state  i_state,
    input  logic [7:0]  i_data_byte,
    input  logic        i_stream_end,
    output t_dec_state  o_state,
    output t_dec_result o_result
);

    logic [CP_W-1:0]   shifted;
    logic [CP_W-1:0]   cp;
    logic              emit_cp;
    logic [LINE_W-1:0] line_next;

    assign shifted = {i_state.partial[CP_W-7:0], i_data_byte[5:0]};

    always_comb begin
        o_state = i_state;
        cp      = '0;
        emit_cp = 1'b0;
        if (i_stream_end) begin
            o_state.partial   = '0;
            o_state.remaining = REM_NONE;
        end else if (i_state.remaining != REM_NONE) begin
            // Take continuation bits blindly; finish when the count runs out.
            o_state.remaining = i_state.remaining - REM_ONE;
            if (i_state.remaining == REM_ONE) begin
                o_state.partial = '0;
                cp              = shifted;
                emit_cp         = 1'b1;
            end else begin
                o_state.partial = shifted;
            end
        end else begin
            case (i_data_byte) inside
                8'b110?????: begin
                    o_state.partial   = CP_W'(i_data_byte[4:0]);
                    o_state.remaining = REM_ONE;
                end
                8'b1110????: begin
                    o_state.partial   = CP_W'(i_data_byte[3:0]);
                    o_state.remaining = REM_TWO;
                end
                8'b11110???: begin
                    o_state.partial   = CP_W'(i_data_byte[2:0]);
                    o_state.remaining = REM_THREE;
                end
                default: begin
                    cp      = CP_W'(i_data_byte);
                    emit_cp = 1'b1;
                end
            endcase
        end

        // Advance the line count on newline, saturate at the top.
        line_next = i_state.line;
        if (emit_cp && cp == CP_W'(NEWLINE) && i_state.line != LINE_MAX) begin
            line_next = i_state.line + LINE_W'(1);
        end
        o_state.line = line_next;
    end

    assign o_result.emit        = emit_cp || i_stream_end;
    assign o_result.code_point  = cp;
    assign o_result.end_seen    = i_stream_end;
    assign o_result.line_number = line_next;

endmodule

// ===== rtl/core/utf8d_checker.sv =====
// Checker: port-level assertions for the UTF-8 stream decoder, bound to the top level.
module utf8d_checker
    import utf8d_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_in_stall,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input logic [CP_W-1:0]   o_code_point,
    input logic              o_end_seen,
    input logic [LINE_W-1:0] o_line_number
);

    // Reset empties the result register.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // A stalled result holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_code_point)
            && $stable(o_end_seen) && $stable(o_line_number))
        else $error("stalled result changed");

    // An end result carries no code point.
    a_end_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_end_seen |-> o_code_point == '0)
        else $error("end result with nonzero code point");

    // Line numbers start at one and never wrap to zero.
    a_line_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_line_number != '0)
        else $error("line number zero");

    // Input stalls only behind a full, stalled result register.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without output backpressure");

endmodule

bind utf8_stream_decoder utf8d_checker u_utf8d_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_code_point  (o_code_point),
    .o_end_seen    (o_end_seen),
    .o_line_number (o_line_number)
);

// ===== tb/sv/tb_utf8_stream_decoder.sv =====
// Testbench for the UTF-8 stream decoder: directed and random byte streams checked against a predictor.
`timescale 1ns / 100ps

module tb_utf8_stream_decoder;
    import utf8d_pkg::*;

    // Lead byte classes: mask and tag for each sequence length, plus payload masks.
    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_TAG  = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_TAG  = 8'hE0;
    localparam logic [7:0] LEAD4_MASK = 8'hF8;
    localparam logic [7:0] LEAD4_TAG  = 8'hF0;
    localparam logic [7:0] LEAD2_BITS = 8'h1F;
    localparam logic [7:0] LEAD3_BITS = 8'h0F;
    localparam logic [7:0] LEAD4_BITS = 8'h07;

    localparam int CYCLE_LIMIT    = 200000;
    localparam int RANDOM_ITEMS   = 1700;
    localparam int HOLD_CYCLES    = 150;
    localparam int DRAIN_CYCLES   = 8;

    // One decoded code point (or end marker) as the block should report it.
    typedef struct {
        logic [CP_W-1:0]   code_point;
        logic              end_seen;
        logic [LINE_W-1:0] line_number;
    } t_cp_result;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [7:0]        in_byte = 8'h00;
    logic              in_end = 1'b0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [CP_W-1:0]   out_cp;
    logic              out_end;
    logic [LINE_W-1:0] out_line;

    // Predictor state: partial code point, continuation bytes left, line count.
    logic [CP_W-1:0]   dec_partial = '0;
    logic [REM_W-1:0]  dec_left = REM_NONE;
    logic [LINE_W-1:0] dec_line = LINE_W'(1);

    t_cp_result pending_cps[$];
    int         errors = 0;
    int         items_sent = 0;
    int         cycle_count = 0;
    bit         no_idle = 1'b0;
    int         hold_req_seq = 0;

    utf8_stream_decoder u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_data_byte   (in_byte),
        .i_stream_end  (in_end),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_code_point  (out_cp),
        .o_end_seen    (out_end),
        .o_line_number (out_line)
    );

    always #5 i_clk = ~i_clk;

    // Give up after a generous number of cycles; a hang is a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Output stall: a long hold-off when requested, none during a quiet stretch,
    // otherwise stall with a probability of about 35 percent.
    always @(negedge i_clk) begin : rx_stall_gen
        int hold_count;
        int hold_seen_seq;
        if (hold_req_seq != hold_seen_seq) begin
            hold_seen_seq = hold_req_seq;
            hold_count = HOLD_CYCLES;
        end
        if (hold_count > 0) begin
            out_stall <= 1'b1;
            hold_count = hold_count - 1;
        end else if (no_idle) begin
            out_stall <= 1'b0;
        end else begin
            out_stall <= ($urandom_range(99) < 35);
        end
    end

    // Compare each accepted result with the oldest expected code point.
    always @(posedge i_clk) begin : cp_checker
        t_cp_result exp_cp;
        if (i_rst_n && out_valid && !out_stall) begin
            if (pending_cps.size() == 0) begin
                $display("%0t: unexpected result cp=%h end=%b line=%0d",
                         $time, out_cp, out_end, out_line);
                errors++;
            end else begin
                exp_cp = pending_cps.pop_front();
                if (out_cp !== exp_cp.code_point) begin
                    $display("%0t: code_point expected %h actual %h",
                             $time, exp_cp.code_point, out_cp);
                    errors++;
                end
                if (out_end !== exp_cp.end_seen) begin
                    $display("%0t: end_seen expected %b actual %b",
                             $time, exp_cp.end_seen, out_end);
                    errors++;
                end
                if (out_line !== exp_cp.line_number) begin
                    $display("%0t: line_number expected %0d actual %0d",
                             $time, exp_cp.line_number, out_line);
                    errors++;
                end
            end
        end
    end

    // Queue one code point and advance the line count on a newline, saturating.
    task automatic push_code_point(input logic [CP_W-1:0] cp);
        t_cp_result r;
        if (cp == CP_W'(NEWLINE) && dec_line != LINE_MAX)
            dec_line = dec_line + 1'b1;
        r.code_point  = cp;
        r.end_seen    = 1'b0;
        r.line_number = dec_line;
        pending_cps.push_back(r);
    endtask

    // Advance the decoder prediction by one accepted item.
    task automatic decode_byte(input logic [7:0] b, input logic e);
        t_cp_result r;
        if (e) begin
            // End of stream: drop any partial sequence, keep the line count.
            dec_partial = '0;
            dec_left    = REM_NONE;
            r.code_point  = '0;
            r.end_seen    = 1'b1;
            r.line_number = dec_line;
            pending_cps.push_back(r);
        end else if (dec_left != REM_NONE) begin
            // Continuation bytes are not checked: shift in the low six bits.
            dec_partial = {dec_partial[CP_W-7:0], b[5:0]};
            dec_left    = dec_left - 1'b1;
            if (dec_left == REM_NONE) begin
                push_code_point(dec_partial);
                dec_partial = '0;
            end
        end else if (!b[7]) begin
            push_code_point(CP_W'(b));
        end else if ((b & LEAD2_MASK) == LEAD2_TAG) begin
            dec_partial = CP_W'(b & LEAD2_BITS);
            dec_left    = REM_ONE;
        end else if ((b & LEAD3_MASK) == LEAD3_TAG) begin
            dec_partial = CP_W'(b & LEAD3_BITS);
            dec_left    = REM_TWO;
        end else if ((b & LEAD4_MASK) == LEAD4_TAG) begin
            dec_partial = CP_W'(b & LEAD4_BITS);
            dec_left    = REM_THREE;
        end else begin
            // Stray continuation or invalid lead passes through as itself.
            push_code_point(CP_W'(b));
        end
    endtask

    // Offer one item, maybe after a random gap; return at the falling edge
    // after it was accepted. Valid stays high for a following item.
    task automatic send_item(input logic [7:0] b, input logic e);
        int gap;
        if (!no_idle && $urandom_range(99) < 35) begin
            in_valid <= 1'b0;
            gap = $urandom_range(1, 4);
            repeat (gap) @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        in_end   <= e;
        do @(posedge i_clk); while (in_stall);
        decode_byte(b, e);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_item(b, 1'b0);
    endtask

    task automatic send_end();
        send_item(8'($urandom), 1'b1);
    endtask

    // Drop valid and hold until every expected result has come out.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_cps.size() != 0) @(negedge i_clk);
    endtask

    task automatic test_ascii_extremes();
        send_byte(8'h00);
        send_byte(8'h7F);
        send_byte(NEWLINE);
        send_byte(8'h41);
    endtask

    task automatic test_multibyte();
        // Two, three and four byte sequences, the largest payload, an overlong
        // form, a surrogate, and unchecked continuations with high bits set.
        send_byte(8'hC2); send_byte(8'hA9);
        send_byte(8'hE2); send_byte(8'h82); send_byte(8'hAC);
        send_byte(8'hF0); send_byte(8'h9F); send_byte(8'h98); send_byte(8'h80);
        send_byte(8'hF7); send_byte(8'hBF); send_byte(8'hBF); send_byte(8'hBF);
        send_byte(8'hC0); send_byte(8'h8A);
        send_byte(8'hED); send_byte(8'hA0); send_byte(8'h80);
        send_byte(8'hDF); send_byte(8'hFF);
    endtask

    task automatic test_stray_bytes();
        send_byte(8'h80);
        send_byte(8'hBF);
        send_byte(8'hF8);
        send_byte(8'hFF);
    endtask

    task automatic test_stream_end();
        // End in the middle of a sequence, then a fresh stream.
        send_byte(8'hE2);
        send_byte(8'h82);
        send_item(8'hFF, 1'b1);
        send_byte(8'h82);
        send_item(8'h00, 1'b1);
        send_byte(NEWLINE);
    endtask

    // Hold the output off for a long stretch while items keep coming, so the
    // block fills and stalls its input.
    task automatic test_output_holdoff();
        int i;
        hold_req_seq++;
        for (i = 0; i < 40; i++)
            send_byte(($urandom_range(9) == 0) ? NEWLINE : 8'($urandom_range(8'h7F)));
    endtask

    // Pause the sender until the pipeline is empty, then resume.
    task automatic test_drain_pause();
        int i;
        for (i = 0; i < 6; i++)
            send_byte(8'($urandom_range(8'h20, 8'h7E)));
        wait_drained();
        repeat ($urandom_range(3, 12)) @(negedge i_clk);
        send_byte(8'hC3);
        send_byte(8'hBC);
    endtask

    // Send one sequence with random payload, a continuation now and then a random
    // byte; a broken one stops short so the next byte sent lands as a continuation.
    task automatic send_sequence(input int len, input bit broken);
        logic [7:0] lead;
        int         n_cont;
        int         k;
        case (len)
            2:       lead = {3'b110, 5'($urandom)};
            3:       lead = {4'b1110, 4'($urandom)};
            default: lead = {5'b11110, 3'($urandom)};
        endcase
        n_cont = broken ? $urandom_range(0, len - 2) : len - 1;
        send_byte(lead);
        for (k = 0; k < n_cont; k++) begin
            if ($urandom_range(19) == 0)
                send_byte(8'($urandom));
            else
                send_byte({2'b10, 6'($urandom)});
        end
    endtask

    task automatic test_random_stream();
        int start;
        int kind;
        start = items_sent;
        while (items_sent < start + RANDOM_ITEMS) begin
            // Hold a quiet stretch on both sides partway through.
            no_idle = (items_sent - start >= 600) && (items_sent - start < 850);
            kind = $urandom_range(99);
            if (kind < 35)
                send_byte(8'($urandom_range(8'h7F)));
            else if (kind < 45)
                send_byte(NEWLINE);
            else if (kind < 60)
                send_sequence(2, 1'b0);
            else if (kind < 72)
                send_sequence(3, 1'b0);
            else if (kind < 82)
                send_sequence(4, 1'b0);
            else if (kind < 88)
                send_sequence($urandom_range(2, 4), 1'b1);
            else if (kind < 97)
                send_byte(8'($urandom));
            else
                send_end();
        end
        no_idle = 1'b0;
    endtask

    initial begin
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_ascii_extremes();
        test_multibyte();
        test_stray_bytes();
        test_stream_end();
        test_output_holdoff();
        test_drain_pause();
        test_random_stream();

        // Flush, let any late result surface, then report.
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/utf8d_pkg.sv
rtl/core/utf8d_step.sv
rtl/core/utf8_stream_decoder.sv
rtl/core/utf8d_checker.sv
tb/sv/tb_utf8_stream_decoder.sv
